>>> src/qte_pkg.sv
`timescale 1ns / 1ps

package qte_pkg;

	localparam int QW    = 16;
	localparam int AW    = 16;
	localparam int NSTG  = 16;
	localparam int NRUN  = (NSTG < 32) ? NSTG : 32;
	localparam int QFRAC = QW - 2;
	localparam int AFRAC = AW - 3;
	localparam int ZFRAC = 30;
	localparam int RSH   = ZFRAC - AFRAC;
	localparam int ZW    = 34;
	localparam int PW    = QW + 2;
	localparam int SW    = QW + 4;
	localparam int DW    = QW + 6;
	localparam int SQN   = QW - 1;
	localparam int RW    = 2 * SQN;
	localparam int SIW   = 5;
	localparam int LAT   = 4 + SQN + NRUN;

	localparam logic signed [SW-1:0] ONE = SW'(1) <<< QFRAC;
	localparam logic signed [ZW-1:0] PI_Z = 34'sd3373259426;
	localparam logic signed [ZW-1:0] HALF_PI_Z = 34'sd1686629713;
	localparam longint PI_OUT = (64'sd3373259426 + (64'sd1 <<< (RSH - 1))) >>> RSH;
	localparam longint HPI_OUT = (64'sd1686629713 + (64'sd1 <<< (RSH - 1))) >>> RSH;

	typedef struct packed {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 zero;
	} cordic_t;

	typedef struct packed {
		logic [RW-1:0] rem;
		logic [RW-1:0] res;
	} sq_t;

	function automatic logic signed [ZW-1:0] atan_tab(input logic [SIW-1:0] i);
		logic signed [ZW-1:0] v;
		case (i)
			5'd0:  v = ZW'(32'h3243F6A8);
			5'd1:  v = ZW'(32'h1DAC6705);
			5'd2:  v = ZW'(32'h0FADBAFC);
			5'd3:  v = ZW'(32'h07F56EA6);
			5'd4:  v = ZW'(32'h03FEAB76);
			5'd5:  v = ZW'(32'h01FFD55B);
			5'd6:  v = ZW'(32'h00FFFAAA);
			5'd7:  v = ZW'(32'h007FFF55);
			5'd8:  v = ZW'(32'h003FFFEA);
			5'd9:  v = ZW'(32'h001FFFFD);
			5'd10: v = ZW'(32'h000FFFFF);
			5'd11: v = ZW'(32'h0007FFFF);
			5'd12: v = ZW'(32'h0003FFFF);
			5'd13: v = ZW'(32'h0001FFFF);
			5'd14: v = ZW'(32'h0000FFFF);
			5'd15: v = ZW'(32'h00007FFF);
			5'd16: v = ZW'(32'h00003FFF);
			5'd17: v = ZW'(32'h00001FFF);
			5'd18: v = ZW'(32'h00000FFF);
			5'd19: v = ZW'(32'h000007FF);
			5'd20: v = ZW'(32'h000003FF);
			5'd21: v = ZW'(32'h000001FF);
			5'd22: v = ZW'(32'h000000FF);
			5'd23: v = ZW'(32'h0000007F);
			5'd24: v = ZW'(32'h0000003F);
			5'd25: v = ZW'(32'h0000001F);
			5'd26: v = ZW'(32'h0000000F);
			5'd27: v = ZW'(32'h00000008);
			5'd28: v = ZW'(32'h00000004);
			5'd29: v = ZW'(32'h00000002);
			5'd30: v = ZW'(32'h00000001);
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [PW-1:0] qmul(input logic signed [QW-1:0] a,
			input logic signed [QW-1:0] b);
		logic signed [2*QW-1:0] p;
		p = a * b;
		return PW'(p >>> QFRAC);
	endfunction

	function automatic cordic_t prerot(input logic signed [DW-1:0] x,
			input logic signed [DW-1:0] y);
		cordic_t c;
		c.zero = (x == '0) && (y == '0);
		if (x < 0) begin
			if (y >= 0) begin
				c.x = y;
				c.y = -x;
				c.z = HALF_PI_Z;
			end else begin
				c.x = -y;
				c.y = x;
				c.z = -HALF_PI_Z;
			end
		end else begin
			c.x = x;
			c.y = y;
			c.z = '0;
		end
		return c;
	endfunction

	function automatic logic signed [ZW+1:0] round_out(input logic signed [ZW+1:0] z,
			input longint lim);
		logic signed [ZW+1:0] half;
		logic signed [ZW+1:0] r;
		logic signed [ZW+1:0] l;
		half = '0;
		half[RSH-1] = 1'b1;
		l = (ZW+2)'(lim);
		r = (z + half) >>> RSH;
		if (r > l) begin
			r = l;
		end else if (r < -l) begin
			r = -l;
		end
		return r;
	endfunction

endpackage

>>> src/qte_cordic_cell.sv
`timescale 1ns / 1ps

module qte_cordic_cell import qte_pkg::*; (
	input  logic           clk,
	input  logic           en,
	input  logic [SIW-1:0] stage,
	input  cordic_t        d,
	output cordic_t        q
);

	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;
	logic signed [ZW-1:0] da;

	assign dx = d.x >>> stage;
	assign dy = d.y >>> stage;
	assign da = atan_tab(stage);

	always_ff @(posedge clk) begin
		if (en) begin
			q.zero <= d.zero;
			if (d.y >= 0) begin
				q.x <= d.x + dy;
				q.y <= d.y - dx;
				q.z <= d.z + da;
			end else begin
				q.x <= d.x - dy;
				q.y <= d.y + dx;
				q.z <= d.z - da;
			end
		end
	end

endmodule

>>> src/qte_sqrt_cell.sv
`timescale 1ns / 1ps

module qte_sqrt_cell import qte_pkg::*; (
	input  logic           clk,
	input  logic           en,
	input  logic [SIW-1:0] stage,
	input  sq_t            d,
	output sq_t            q
);

	logic [RW-1:0] bitv;
	logic [RW:0]   trial;

	assign bitv  = RW'(1) << {(SIW'(SQN - 1) - stage), 1'b0};
	assign trial = {1'b0, d.res} + {1'b0, bitv};

	always_ff @(posedge clk) begin
		if (en) begin
			if ({1'b0, d.rem} >= trial) begin
				q.rem <= d.rem - trial[RW-1:0];
				q.res <= (d.res >> 1) + bitv;
			end else begin
				q.rem <= d.rem;
				q.res <= d.res >> 1;
			end
		end
	end

endmodule

>>> src/quaternion_to_euler.sv
`timescale 1ns / 1ps
// throughput: one word per cycle while the output word is not stalled, set by the chain of root and cordic cells
// a stalled output word holds the whole chain and the input stalls with it
// reset clears the valid bits only, data registers are not reset

module quaternion_to_euler import qte_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [QW-1:0] quat_w,
	input  logic signed [QW-1:0] quat_x,
	input  logic signed [QW-1:0] quat_y,
	input  logic signed [QW-1:0] quat_z,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [AW-1:0] roll_angle,
	output logic signed [AW-2:0] pitch_angle,
	output logic signed [AW-1:0] yaw_angle
);

	logic            en;
	logic [LAT-1:0]  vld_q;

	logic signed [PW-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, xz_s1, wz_s1, xy_s1, zz_s1;
	logic signed [SW-1:0] rs_s2, rc_s2, ys_s2, yc_s2;
	logic [QW-1:0]        a_s2, b_s2;
	logic signed [SW-1:0] t_c, a_c, b_c;

	cordic_t roll_s3, yaw_s3, pitch_p_q;
	cordic_t roll_c  [NRUN+1];
	cordic_t yaw_c   [NRUN+1];
	cordic_t pitch_c [NRUN+1];
	sq_t     sa_c    [SQN+1];
	sq_t     sb_c    [SQN+1];

	logic signed [AW-1:0] roll_d [SQN];
	logic signed [AW-1:0] yaw_d  [SQN];
	logic signed [ZW+1:0] roll_r, yaw_r, pitch_r, pitch_z;

	assign en        = !(vld_q[LAT-1] && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// products
	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= qmul(quat_w, quat_x);
			yz_s1 <= qmul(quat_y, quat_z);
			xx_s1 <= qmul(quat_x, quat_x);
			yy_s1 <= qmul(quat_y, quat_y);
			wy_s1 <= qmul(quat_w, quat_y);
			xz_s1 <= qmul(quat_x, quat_z);
			wz_s1 <= qmul(quat_w, quat_z);
			xy_s1 <= qmul(quat_x, quat_y);
			zz_s1 <= qmul(quat_z, quat_z);
		end
	end

	// sums and root arguments
	always_comb begin
		t_c = SW'(wy_s1) - SW'(xz_s1);
		a_c = ONE + (t_c <<< 1);
		b_c = ONE - (t_c <<< 1);
		if (a_c < 0) begin
			a_c = '0;
		end else if (a_c > (ONE <<< 1)) begin
			a_c = ONE <<< 1;
		end
		if (b_c < 0) begin
			b_c = '0;
		end else if (b_c > (ONE <<< 1)) begin
			b_c = ONE <<< 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rs_s2 <= (SW'(wx_s1) + SW'(yz_s1)) <<< 1;
			rc_s2 <= ONE - ((SW'(xx_s1) + SW'(yy_s1)) <<< 1);
			ys_s2 <= (SW'(wz_s1) + SW'(xy_s1)) <<< 1;
			yc_s2 <= ONE - ((SW'(yy_s1) + SW'(zz_s1)) <<< 1);
			a_s2  <= a_c[QW-1:0];
			b_s2  <= b_c[QW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_s3   <= prerot(DW'(rc_s2), DW'(rs_s2));
			yaw_s3    <= prerot(DW'(yc_s2), DW'(ys_s2));
			pitch_p_q <= prerot(DW'(sb_c[SQN].res[SQN-1:0]), DW'(sa_c[SQN].res[SQN-1:0]));
		end
	end

	assign sa_c[0].rem = {a_s2, (QFRAC)'(0)};
	assign sa_c[0].res = '0;
	assign sb_c[0].rem = {b_s2, (QFRAC)'(0)};
	assign sb_c[0].res = '0;

	genvar k;
	generate
		for (k = 0; k < SQN; k++) begin : g_sqrt
			qte_sqrt_cell u_sa (
				.clk   (clk),
				.en    (en),
				.stage (SIW'(k)),
				.d     (sa_c[k]),
				.q     (sa_c[k+1])
			);
			qte_sqrt_cell u_sb (
				.clk   (clk),
				.en    (en),
				.stage (SIW'(k)),
				.d     (sb_c[k]),
				.q     (sb_c[k+1])
			);
		end
	endgenerate

	assign roll_c[0]  = roll_s3;
	assign yaw_c[0]   = yaw_s3;
	assign pitch_c[0] = pitch_p_q;

	generate
		for (k = 0; k < NRUN; k++) begin : g_cordic
			qte_cordic_cell u_roll (
				.clk   (clk),
				.en    (en),
				.stage (SIW'(k)),
				.d     (roll_c[k]),
				.q     (roll_c[k+1])
			);
			qte_cordic_cell u_yaw (
				.clk   (clk),
				.en    (en),
				.stage (SIW'(k)),
				.d     (yaw_c[k]),
				.q     (yaw_c[k+1])
			);
			qte_cordic_cell u_pitch (
				.clk   (clk),
				.en    (en),
				.stage (SIW'(k)),
				.d     (pitch_c[k]),
				.q     (pitch_c[k+1])
			);
		end
	endgenerate

	// rounding and range limits
	always_comb begin
		roll_r  = round_out(roll_c[NRUN].zero ? '0 : (ZW+2)'(roll_c[NRUN].z), PI_OUT);
		yaw_r   = round_out(yaw_c[NRUN].zero ? '0 : (ZW+2)'(yaw_c[NRUN].z), PI_OUT);
		pitch_z = (pitch_c[NRUN].zero ? '0 : ((ZW+2)'(pitch_c[NRUN].z) <<< 1))
			- (ZW+2)'(HALF_PI_Z);
		pitch_r = round_out(pitch_z, HPI_OUT);
	end

	// roll and yaw wait for the pitch root
	always_ff @(posedge clk) begin
		if (en) begin
			roll_d[0] <= roll_r[AW-1:0];
			yaw_d[0]  <= yaw_r[AW-1:0];
			for (int i = 1; i < SQN; i++) begin
				roll_d[i] <= roll_d[i-1];
				yaw_d[i]  <= yaw_d[i-1];
			end
			roll_angle  <= roll_d[SQN-1];
			yaw_angle   <= yaw_d[SQN-1];
			pitch_angle <= pitch_r[AW-2:0];
		end
	end

endmodule

>>> src/qte_checker.sv
`timescale 1ns / 1ps

module qte_checker import qte_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic signed [AW-1:0] roll_angle,
	input logic signed [AW-2:0] pitch_angle,
	input logic signed [AW-1:0] yaw_angle
);

	localparam logic signed [AW-1:0] PI_L  = AW'(PI_OUT);
	localparam logic signed [AW-2:0] HPI_L = (AW-1)'(HPI_OUT);

	a_stall_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not track output stall");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(roll_angle)
			&& $stable(pitch_angle) && $stable(yaw_angle))
		else $error("stalled output word changed");

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (roll_angle <= PI_L) && (roll_angle >= -PI_L))
		else $error("roll out of range");

	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (yaw_angle <= PI_L) && (yaw_angle >= -PI_L))
		else $error("yaw out of range");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pitch_angle <= HPI_L) && (pitch_angle >= -HPI_L))
		else $error("pitch out of range");

endmodule

bind quaternion_to_euler qte_checker u_qte_checker (.*);
